@@ hdl/bbq_pkg.sv @@
// Shared types and constants for the byte budget packet queue.
// No dependencies; imported by every module and interface of the block.
package bbq_pkg;

	localparam int SLOT_COUNT_DEF = 64;
	localparam int HANDLE_W       = 32;
	localparam int SIZE_W         = 24;
	localparam int BYTES_W        = 32;
	localparam int STATUS_W       = 3;
	localparam int CMD_W          = 2;
	localparam logic [BYTES_W-1:0] CAPACITY_RESET = 32'd1048576;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH  = 2'd0,
		CMD_POP   = 2'd1,
		CMD_CLOSE = 2'd2,
		CMD_RESET = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK          = 3'd0,
		STS_NO_ROOM     = 3'd1,
		STS_CLOSED_PUSH = 3'd2,
		STS_EMPTY       = 3'd3,
		STS_DRAINED     = 3'd4
	} status_t;

	typedef struct packed {
		logic [HANDLE_W-1:0] chunk_handle;
		logic [SIZE_W-1:0]   chunk_size;
	} slot_t;

	typedef struct packed {
		status_t             status;
		logic [HANDLE_W-1:0] out_handle;
		logic [SIZE_W-1:0]   out_size;
		logic [BYTES_W-1:0]  queued_bytes;
	} result_t;

endpackage

@@ hdl/bbq_if.sv @@
// Request and response channel interfaces of the byte budget packet queue.
// Depends on bbq_pkg for field widths.
interface bbq_in_if import bbq_pkg::*;;
	logic                valid;
	logic                ready;
	logic [CMD_W-1:0]    command;
	logic [HANDLE_W-1:0] chunk_handle;
	logic [SIZE_W-1:0]   chunk_size;

	modport source (output valid, command, chunk_handle, chunk_size, input ready);
	modport sink   (input valid, command, chunk_handle, chunk_size, output ready);
endinterface

interface bbq_out_if import bbq_pkg::*; #(
	parameter int LEVEL_W = 7
);
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [HANDLE_W-1:0] out_handle;
	logic [SIZE_W-1:0]   out_size;
	logic [LEVEL_W-1:0]  level;
	logic [BYTES_W-1:0]  queued_bytes;

	modport source (output valid, status, out_handle, out_size, level, queued_bytes,
		input ready);
	modport sink   (input valid, status, out_handle, out_size, level, queued_bytes,
		output ready);
endinterface

@@ hdl/bbq_slot_mem.sv @@
// Descriptor store: one write port, one read port, registered read data.
// Depends on bbq_pkg for the slot type.
module bbq_slot_mem import bbq_pkg::*; #(
	parameter int DEPTH = SLOT_COUNT_DEF,
	localparam int IDX_W = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  slot_t            wr_data,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_addr,
	output slot_t            rd_data
);

	slot_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

@@ hdl/bbq_out_stage.sv @@
// Output register of the response channel; holds a word until it is taken.
// Depends on bbq_pkg and the bbq_out_if interface.
module bbq_out_stage import bbq_pkg::*; #(
	parameter int LEVEL_W = 7
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  result_t            result,
	input  logic [LEVEL_W-1:0] level,
	output logic               free,
	bbq_out_if.source          rsp
);

	logic               valid_q;
	result_t            result_q;
	logic [LEVEL_W-1:0] level_q;

	assign free = !valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= result;
			level_q  <= level;
		end
	end

	assign rsp.valid        = valid_q;
	assign rsp.status       = result_q.status;
	assign rsp.out_handle   = result_q.out_handle;
	assign rsp.out_size     = result_q.out_size;
	assign rsp.queued_bytes = result_q.queued_bytes;
	assign rsp.level        = level_q;

endmodule

@@ hdl/byte_budget_packet_queue_top.sv @@
// Byte budget packet queue: ring of descriptors with slot and byte limits.
// Push, close, reset and pop of an empty queue: output register loads on acceptance.
// Pop with data: store read register, then output register; the request side holds.
// Throughput: 1 word per cycle while rsp.ready is high; pops with data hold requests.
// Reset clears pointers, count, byte total, close flag; arst_n loads capacity 1048576.
// Depends on bbq_pkg, bbq_if, bbq_slot_mem and bbq_out_stage.
module byte_budget_packet_queue_top import bbq_pkg::*; #(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF,
	localparam int IDX_W = $clog2(SLOT_COUNT),
	localparam int CNT_W = $clog2(SLOT_COUNT + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [BYTES_W-1:0] wr_data,
	bbq_in_if.sink             req,
	bbq_out_if.source          rsp
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_POP  = 2'b10
	} state_t;

	state_t             state_q, state_n;
	logic [IDX_W-1:0]   rd_idx_q, rd_idx_n, wr_idx_q, wr_idx_n;
	logic [CNT_W-1:0]   count_q, count_n;
	logic [BYTES_W-1:0] total_q, total_n, cap_q;
	logic               closed_q, closed_n;

	logic               free, accept, load, mem_we, mem_re, full, over;
	logic [BYTES_W:0]   sum;
	logic [BYTES_W-1:0] pop_size;
	slot_t              wr_slot, rd_slot;
	result_t            result;

	assign req.ready = (state_q == ST_IDLE) && free;
	assign accept    = req.valid && req.ready;

	assign sum      = {1'b0, total_q} + (BYTES_W+1)'(req.chunk_size);
	assign over     = sum > {1'b0, cap_q};
	assign full     = count_q == CNT_W'(SLOT_COUNT);
	assign pop_size = BYTES_W'(rd_slot.chunk_size);

	assign wr_slot.chunk_handle = req.chunk_handle;
	assign wr_slot.chunk_size   = req.chunk_size;

	always_comb begin
		state_n  = state_q;
		rd_idx_n = rd_idx_q;
		wr_idx_n = wr_idx_q;
		count_n  = count_q;
		total_n  = total_q;
		closed_n = closed_q;
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		load     = 1'b0;
		result   = '0;
		result.status = STS_OK;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					load = 1'b1;
					case (cmd_t'(req.command))
						CMD_PUSH: begin
							if (closed_q) begin
								result.status     = STS_CLOSED_PUSH;
								result.out_handle = req.chunk_handle;
							end else if (full || (total_q != '0 && over)) begin
								result.status = STS_NO_ROOM;
							end else begin
								mem_we   = 1'b1;
								wr_idx_n = (wr_idx_q == IDX_W'(SLOT_COUNT - 1)) ? '0 :
									wr_idx_q + IDX_W'(1);
								count_n  = count_q + CNT_W'(1);
								total_n  = sum[BYTES_W-1:0];
							end
						end
						CMD_POP: begin
							if (count_q == '0) begin
								result.status = closed_q ? STS_DRAINED : STS_EMPTY;
							end else begin
								load     = 1'b0;
								mem_re   = 1'b1;
								rd_idx_n = (rd_idx_q == IDX_W'(SLOT_COUNT - 1)) ? '0 :
									rd_idx_q + IDX_W'(1);
								count_n  = count_q - CNT_W'(1);
								state_n  = ST_POP;
							end
						end
						CMD_CLOSE: begin
							closed_n = 1'b1;
						end
						default: begin
							rd_idx_n = '0;
							wr_idx_n = '0;
							count_n  = '0;
							total_n  = '0;
							closed_n = 1'b0;
						end
					endcase
				end
			end
			ST_POP: begin
				load              = 1'b1;
				result.out_handle = rd_slot.chunk_handle;
				result.out_size   = rd_slot.chunk_size;
				total_n           = (total_q >= pop_size) ? total_q - pop_size : '0;
				state_n           = ST_IDLE;
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
		result.queued_bytes = total_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rd_idx_q <= '0;
			wr_idx_q <= '0;
			count_q  <= '0;
			total_q  <= '0;
			closed_q <= 1'b0;
			cap_q    <= CAPACITY_RESET;
		end else begin
			state_q  <= state_n;
			rd_idx_q <= rd_idx_n;
			wr_idx_q <= wr_idx_n;
			count_q  <= count_n;
			total_q  <= total_n;
			closed_q <= closed_n;
			if (wr_en) begin
				cap_q <= wr_data;
			end
		end
	end

	bbq_slot_mem #(
		.DEPTH(SLOT_COUNT)
	) u_slot_mem (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (wr_idx_q),
		.wr_data (wr_slot),
		.rd_en   (mem_re),
		.rd_addr (rd_idx_q),
		.rd_data (rd_slot)
	);

	bbq_out_stage #(
		.LEVEL_W(CNT_W)
	) u_out_stage (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.result (result),
		.level  (count_n),
		.free   (free),
		.rsp    (rsp)
	);

	a_pop_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POP) |-> !rsp.valid)
		else $error("pop result would overwrite a pending word");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(SLOT_COUNT))
		else $error("entry count above slot count");

	a_empty_no_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && count_q == '0) |-> (total_q == '0))
		else $error("empty queue holds bytes");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (rd_idx_q == wr_idx_q))
		else $error("empty queue with unequal indexes");

endmodule

@@ tb/byte_budget_packet_queue_top_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for byte_budget_packet_queue_top: predicts every reply word
// and compares it field by field. Depends on bbq_pkg, bbq_if and the block's RTL.
module byte_budget_packet_queue_top_test;
	import bbq_pkg::*;

	localparam int SLOTS   = SLOT_COUNT_DEF;
	localparam int LEVEL_W = $clog2(SLOTS + 1);

	typedef struct {
		status_t             status;
		logic [HANDLE_W-1:0] handle;
		logic [SIZE_W-1:0]   size;
		logic [LEVEL_W-1:0]  level;
		logic [BYTES_W-1:0]  queued;
	} reply_t;

	class packet_queue_scoreboard;
		logic [HANDLE_W-1:0] slot_handle [SLOTS];
		logic [SIZE_W-1:0]   slot_size [SLOTS];
		int unsigned         rd_ptr;
		int unsigned         wr_ptr;
		int unsigned         held;
		logic [BYTES_W-1:0]  held_bytes;
		logic [BYTES_W-1:0]  capacity;
		bit                  closed;
		reply_t              pending_replies [$];
		int                  failures;

		function new();
			clear_queue();
			capacity = CAPACITY_RESET;
			failures = 0;
		endfunction

		function void clear_queue();
			rd_ptr = 0;
			wr_ptr = 0;
			held = 0;
			held_bytes = '0;
			closed = 1'b0;
		endfunction

		function void set_capacity(logic [BYTES_W-1:0] value);
			capacity = value;
		endfunction

		function int pending();
			return pending_replies.size();
		endfunction

		// Advance the queue state by one accepted request word and hold its reply.
		function void note_request(cmd_t cmd, logic [HANDLE_W-1:0] handle,
			logic [SIZE_W-1:0] size);
			reply_t           r;
			logic [BYTES_W:0] sum;
			r = '{STS_OK, '0, '0, '0, '0};
			sum = {1'b0, held_bytes} + (BYTES_W + 1)'(size);
			case (cmd)
				CMD_PUSH: begin
					if (closed) begin
						r.status = STS_CLOSED_PUSH;
						r.handle = handle;
					end else if (held == SLOTS ||
						(held_bytes != 0 && sum > {1'b0, capacity})) begin
						r.status = STS_NO_ROOM;
					end else begin
						slot_handle[wr_ptr] = handle;
						slot_size[wr_ptr] = size;
						wr_ptr = (wr_ptr + 1) % SLOTS;
						held++;
						held_bytes = sum[BYTES_W-1:0];
					end
				end
				CMD_POP: begin
					if (held == 0) begin
						r.status = closed ? STS_DRAINED : STS_EMPTY;
					end else begin
						r.handle = slot_handle[rd_ptr];
						r.size = slot_size[rd_ptr];
						rd_ptr = (rd_ptr + 1) % SLOTS;
						held--;
						held_bytes = (held_bytes >= BYTES_W'(r.size)) ?
							held_bytes - BYTES_W'(r.size) : '0;
					end
				end
				CMD_CLOSE: closed = 1'b1;
				default: clear_queue();
			endcase
			r.level = LEVEL_W'(held);
			r.queued = held_bytes;
			pending_replies.push_back(r);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
				failures++;
			end
		endfunction

		function void check_result(logic [STATUS_W-1:0] status, logic [HANDLE_W-1:0] handle,
			logic [SIZE_W-1:0] size, logic [LEVEL_W-1:0] level, logic [BYTES_W-1:0] queued);
			reply_t r;
			if (pending_replies.size() == 0) begin
				$error("status: expected no word, got 0x%0h", status);
				failures++;
				return;
			end
			r = pending_replies.pop_front();
			compare_field("status", 32'(r.status), 32'(status));
			compare_field("out_handle", 32'(r.handle), 32'(handle));
			compare_field("out_size", 32'(r.size), 32'(size));
			compare_field("level", 32'(r.level), 32'(level));
			compare_field("queued_bytes", 32'(r.queued), 32'(queued));
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               wr_en;
	logic [BYTES_W-1:0] wr_data;
	bit                 tx_gaps;
	bit                 rx_stalls;

	packet_queue_scoreboard scoreboard = new();

	bbq_in_if                      req ();
	bbq_out_if #(.LEVEL_W(LEVEL_W)) rsp ();

	byte_budget_packet_queue_top #(.SLOT_COUNT(SLOTS)) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_data (wr_data),
		.req     (req),
		.rsp     (rsp)
	);

	always #1 clk = ~clk;

	initial begin
		#400000;
		$display("byte_budget_packet_queue_top regression: fail");
		$finish;
	end

	task automatic send_word(cmd_t cmd, logic [HANDLE_W-1:0] handle, logic [SIZE_W-1:0] size);
		int gap;
		gap = tx_gaps ? $urandom_range(0, 19) : 0;
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.command <= cmd;
		req.chunk_handle <= handle;
		req.chunk_size <= size;
		do @(posedge clk); while (req.ready !== 1'b1);
		scoreboard.note_request(cmd, handle, size);
	endtask

	task automatic write_capacity(logic [BYTES_W-1:0] value);
		req.valid <= 1'b0;
		while (scoreboard.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		wr_en <= 1'b1;
		wr_data <= value;
		@(posedge clk);
		wr_en <= 1'b0;
		scoreboard.set_capacity(value);
	endtask

	function automatic logic [SIZE_W-1:0] draw_size();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3: return SIZE_W'($urandom);
			4, 5: return SIZE_W'($urandom_range(0, 4095));
			default: return SIZE_W'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic random_phase(int count);
		int push_pct;
		int seg_left;
		int pick;
		push_pct = 50;
		seg_left = 0;
		for (int i = 0; i < count; i++) begin
			if (seg_left == 0) begin
				seg_left = $urandom_range(20, 80);
				case ($urandom_range(0, 3))
					0: push_pct = 95;
					1: push_pct = 75;
					2: push_pct = 50;
					default: push_pct = 20;
				endcase
				tx_gaps = $urandom_range(0, 2) != 0;
				rx_stalls = $urandom_range(0, 2) != 0;
			end
			seg_left--;
			pick = $urandom_range(0, 99);
			if (pick < 1)
				send_word(CMD_CLOSE, $urandom, draw_size());
			else if (pick < 3)
				send_word(CMD_RESET, $urandom, draw_size());
			else if (pick < 3 + push_pct * 97 / 100)
				send_word(CMD_PUSH, $urandom, draw_size());
			else
				send_word(CMD_POP, $urandom, draw_size());
		end
	endtask

	initial begin : drain
		int stall;
		rsp.ready = 1'b0;
		@(posedge clk);
		forever begin
			stall = rx_stalls ? $urandom_range(0, 19) : 0;
			if (stall > 0) begin
				rsp.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			do @(posedge clk); while (rsp.valid !== 1'b1);
			scoreboard.check_result(rsp.status, rsp.out_handle, rsp.out_size, rsp.level,
				rsp.queued_bytes);
		end
	end

	initial begin
		logic [BYTES_W-1:0] caps [8];
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_data = '0;
		req.valid = 1'b0;
		req.command = CMD_PUSH;
		req.chunk_handle = '0;
		req.chunk_size = '0;
		tx_gaps = 1'b0;
		rx_stalls = 1'b0;
		caps = '{32'hFFFF_FFFF, 32'd0, 32'd1000, CAPACITY_RESET, $urandom, 32'd4096,
			32'h00FF_FFFF, 32'd100000};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(CMD_POP, '0, '0);
		send_word(CMD_PUSH, '0, '0);
		send_word(CMD_PUSH, '1, '1);
		send_word(CMD_PUSH, 32'h1234_5678, 24'd1);
		send_word(CMD_POP, '0, '0);
		send_word(CMD_POP, '0, '0);
		send_word(CMD_POP, '0, '0);
		tx_gaps = 1'b1;
		rx_stalls = 1'b1;
		send_word(CMD_PUSH, 32'hA5A5_A5A5, SIZE_W'(CAPACITY_RESET));
		send_word(CMD_PUSH, 32'h5A5A_5A5A, '0);
		send_word(CMD_PUSH, 32'h0F0F_0F0F, 24'd1);
		send_word(CMD_CLOSE, '0, '0);
		send_word(CMD_CLOSE, '0, '0);
		send_word(CMD_PUSH, 32'hDEAD_BEEF, 24'h000100);
		send_word(CMD_POP, '0, '0);
		send_word(CMD_POP, '0, '0);
		send_word(CMD_POP, '0, '0);
		send_word(CMD_PUSH, 32'hCAFE_F00D, 24'd7);
		send_word(CMD_RESET, '0, '0);
		send_word(CMD_POP, '0, '0);
		send_word(CMD_PUSH, 32'h8000_0001, 24'h800001);
		send_word(CMD_CLOSE, '0, '0);
		send_word(CMD_RESET, '0, '0);

		foreach (caps[p]) begin
			write_capacity(caps[p]);
			if (p == 0) begin
				tx_gaps = 1'b0;
				rx_stalls = 1'b0;
				repeat (68) send_word(CMD_PUSH, $urandom, draw_size());
			end
			random_phase(85);
		end

		req.valid <= 1'b0;
		while (scoreboard.pending() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (scoreboard.failures == 0)
			$display("byte_budget_packet_queue_top regression: pass");
		else
			$display("byte_budget_packet_queue_top regression: fail");
		$finish;
	end
endmodule
